// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame transform RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("check failed");
`else
`define CHK_IMPLY(lbl, clk, rstn, a, b)
`define CHK_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

// ===== rtl/fgt_pkg.sv =====
// Package of the frame transform: mode codes and register indexes.
// Depends on nothing.
package fgt_pkg;
	localparam logic [2:0] MODE_ROT90 = 3'd0;
	localparam logic [2:0] MODE_ROT270 = 3'd1;
	localparam logic [2:0] MODE_FLIPH = 3'd2;
	localparam logic [2:0] MODE_FLIPV = 3'd3;
	localparam logic [2:0] MODE_SCALE = 3'd4;
	localparam logic [2:0] MODE_CROP = 3'd5;
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_IN_W = 3'd1;
	localparam logic [2:0] REG_IN_H = 3'd2;
	localparam logic [2:0] REG_OUT_W = 3'd3;
	localparam logic [2:0] REG_OUT_H = 3'd4;
	localparam logic [2:0] REG_CROP_X = 3'd5;
	localparam logic [2:0] REG_CROP_Y = 3'd6;
	localparam int CROP_MIN = 3;
	typedef struct packed {
		logic last;
		logic bad;
		logic zero;
	} fgt_flags_t;
endpackage

// ===== rtl/frame_geometric_transform_top.sv =====
// Top level of the frame transform: address generation, frame memory, output register.
// Depends on fgt_pkg and assert_macros.svh.
//
// Channel   Dir  Payload
// s_axis    in   tuser=func, tdata[7:0]=pixel_in
// m_axis    out  tdata[7:0]=pixel_out, tlast=frame_end, tuser=bad_crop
// cfg       in   cfg_we, cfg_index, cfg_data[8:0]
//
// A write leaves the block idle, and the input is ready again on the next cycle.
// A read registers its source address, reads the frame memory into a register, and presents
// the result from the output register. The input is ready again in the cycle after the
// result transfer. In scale mode the source row and column are each found by a restoring
// divider, one bit per cycle, and a wait state then forms the address from them.
// One item is in flight at a time, and a result that waits holds off writes as well.
// Reset clears the counters and the registers but rdata_q. The frame memory is not cleared.
`include "assert_macros.svh"
module frame_geometric_transform_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // pixel_in
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // pixel_out
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,  // bad_crop
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_DIVR, ST_DIVC, ST_RD, ST_WAIT, ST_OUT} st_t;
	st_t st_q;
	logic [2:0] mode_q;
	logic [8:0] inw_q, inh_q, outw_q, outh_q;
	logic [7:0] cx_q, cy_q;
	logic [15:0] lp_q;
	logic [8:0] row_q, col_q;
	logic [7:0] mem [0:65535];
	logic [7:0] rdata_q;
	logic [15:0] addr_q;
	logic [15:0] addr_hold;
	logic [16:0] num_q;
	logic [8:0] den_q, quo_q, rrow_q;
	logic [8:0] rem_q;
	logic [4:0] cnt_q;
	logic [16:0] cnum_q;
	fgt_pkg::fgt_flags_t fl_q;
	logic [7:0] pix_q;

	// Clamp a dimension register to 1..256.
	function automatic logic [8:0] cl(input logic [8:0] v);
		if (v == 9'd0) return 9'd1;
		if (v > 9'd256) return 9'd256;
		return v;
	endfunction

	logic [8:0] w, h, ow, oh, r, c;
	logic [16:0] size;
	logic func;
	logic badc, lst, unused;
	assign func = s_axis_tuser;
	assign w = cl(inw_q);
	assign h = cl(inh_q);
	assign unused = (mode_q > fgt_pkg::MODE_CROP);
	always_comb begin
		if (mode_q == fgt_pkg::MODE_ROT90 || mode_q == fgt_pkg::MODE_ROT270) begin
			ow = h; oh = w;
		end else if (mode_q == fgt_pkg::MODE_FLIPH || mode_q == fgt_pkg::MODE_FLIPV) begin
			ow = w; oh = h;
		end else begin
			ow = cl(outw_q); oh = cl(outh_q);
		end
	end
	assign size = 17'(w) * 17'(h);
	always_comb begin
		if (row_q >= oh || col_q >= ow) begin
			r = 9'd0; c = 9'd0;
		end else begin
			r = row_q; c = col_q;
		end
	end
	assign badc = (ow < 9'(fgt_pkg::CROP_MIN)) || (oh < 9'(fgt_pkg::CROP_MIN)) ||
		(10'(cx_q) + 10'(ow) > 10'(w)) || (10'(cy_q) + 10'(oh) > 10'(h));
	assign lst = (r == oh - 9'd1) && (c == ow - 9'd1);

	// Row and column of the source pixel for the non-scale modes.
	logic [8:0] sr, sc;
	always_comb begin
		case (mode_q)
			fgt_pkg::MODE_ROT90: begin sr = c; sc = w - 9'd1 - r; end
			fgt_pkg::MODE_ROT270: begin sr = h - 9'd1 - c; sc = r; end
			fgt_pkg::MODE_FLIPH: begin sr = r; sc = w - 9'd1 - c; end
			fgt_pkg::MODE_FLIPV: begin sr = h - 9'd1 - r; sc = c; end
			default: begin sr = 9'(cy_q) + r; sc = 9'(cx_q) + c; end
		endcase
	end

	logic [16:0] lin;
	assign lin = 17'(sr) * 17'(w) + 17'(sc);
	logic [16:0] slin;
	assign slin = 17'(rrow_q) * 17'(w) + 17'(quo_q);
	logic [9:0] trial;
	assign trial = {rem_q, num_q[16]};
	logic qbit;
	assign qbit = (trial >= 10'(den_q));

	assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_axis_tvalid && s_axis_tready && !func)
			mem[addr_q] <= s_axis_tdata;
		rdata_q <= mem[addr_q];
	end

	always_comb begin
		addr_q = lp_q;
		if (st_q != ST_IDLE) addr_q = addr_hold;
		else if (17'(lp_q) >= size) addr_q = 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mode_q <= fgt_pkg::MODE_ROT90;
			inw_q <= 9'd256; inh_q <= 9'd256; outw_q <= 9'd256; outh_q <= 9'd256;
			cx_q <= 8'd0; cy_q <= 8'd0;
			lp_q <= 16'd0; row_q <= 9'd0; col_q <= 9'd0;
			m_axis_tvalid <= 1'b0;
			fl_q <= '0;
			pix_q <= 8'd0;
			addr_hold <= 16'd0;
			num_q <= 17'd0; cnum_q <= 17'd0;
			den_q <= 9'd1; rem_q <= 9'd0; cnt_q <= 5'd0;
			rrow_q <= 9'd0; quo_q <= 9'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fgt_pkg::REG_MODE: mode_q <= cfg_data[2:0];
					fgt_pkg::REG_IN_W: inw_q <= cfg_data;
					fgt_pkg::REG_IN_H: inh_q <= cfg_data;
					fgt_pkg::REG_OUT_W: outw_q <= cfg_data;
					fgt_pkg::REG_OUT_H: outh_q <= cfg_data;
					fgt_pkg::REG_CROP_X: cx_q <= cfg_data[7:0];
					fgt_pkg::REG_CROP_Y: cy_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						if (!func) begin
							if (17'(addr_q) + 17'd1 >= size) lp_q <= 16'd0;
							else lp_q <= addr_q + 16'd1;
						end else if (unused) begin
							row_q <= 9'd0; col_q <= 9'd0;
							fl_q <= '{last: 1'b1, bad: 1'b0, zero: 1'b1};
							st_q <= ST_OUT;
						end else begin
							fl_q <= '{last: lst, bad: (mode_q == fgt_pkg::MODE_CROP) && badc,
								zero: (mode_q == fgt_pkg::MODE_CROP) && badc};
							if (lst) begin
								row_q <= 9'd0; col_q <= 9'd0;
							end else if (c == ow - 9'd1) begin
								col_q <= 9'd0; row_q <= r + 9'd1;
							end else begin
								row_q <= r; col_q <= c + 9'd1;
							end
							addr_hold <= lin[15:0];
							if (mode_q == fgt_pkg::MODE_SCALE) begin
								num_q <= 17'(h) * 17'(r);
								cnum_q <= 17'(w) * 17'(c);
								den_q <= oh; rem_q <= 9'd0; cnt_q <= 5'd0;
								st_q <= ST_DIVR;
							end else begin
								st_q <= ST_RD;
							end
						end
					end
				end
				ST_DIVR, ST_DIVC: begin
					// One quotient bit per cycle, restoring.
					if (cnt_q == 5'd16) begin
						cnt_q <= 5'd0; rem_q <= 9'd0;
						if (st_q == ST_DIVR) begin
							rrow_q <= {num_q[7:0], qbit};
							num_q <= cnum_q; den_q <= ow;
							st_q <= ST_DIVC;
						end else begin
							quo_q <= {num_q[7:0], qbit};
							st_q <= ST_WAIT;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
						rem_q <= qbit ? 9'(trial - 10'(den_q)) : trial[8:0];
						num_q <= {num_q[15:0], qbit};
					end
				end
				ST_WAIT: begin
					addr_hold <= slin[15:0];
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_OUT;
				default: begin
					pix_q <= fl_q.zero ? 8'd0 : rdata_q;
					m_axis_tvalid <= 1'b1;
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tdata = pix_q;
	assign m_axis_tlast = fl_q.last;
	assign m_axis_tuser = fl_q.bad;

	`CHK_IMPLY(a_one_item, clk, arst_n, m_axis_tvalid, st_q == ST_IDLE)
	`CHK_IMPLY(a_bad_zero, clk, arst_n, m_axis_tvalid && fl_q.bad, pix_q == 8'd0)
	`CHK_NEXT(a_out_next, clk, arst_n, st_q == ST_RD, st_q == ST_OUT)
	`CHK_IMPLY(a_div_count, clk, arst_n, st_q == ST_DIVR || st_q == ST_DIVC, cnt_q <= 5'd16)
endmodule
